/* hw/rtl/ccc_pkg.sv */
`timescale 1ns / 1ps

package ccc_pkg;

	// Credit ceiling and the coin mode that means free play
	localparam logic [6:0] CreditMax    = 7'd99;
	localparam logic [2:0] FreePlayMode = 3'd7;

	// Stream data widths, padded to whole bytes
	localparam int InDataW  = 8;
	localparam int OutDataW = 16;

	// One frame's switch sample
	typedef struct packed {
		logic start_press;
		logic service_switch;
		logic coin_switch;
	} ccc_in_t;

	// One frame's result
	typedef struct packed {
		logic       free_play;
		logic [6:0] credits_now;
		logic       start_granted;
	} ccc_out_t;

	// Coins needed for one award; free play shares the first entry
	function automatic logic [2:0] coins_needed(input logic [2:0] mode);
		logic [2:0] n;
		case (mode)
			3'd0:    n = 3'd1;
			3'd1:    n = 3'd1;
			3'd2:    n = 3'd1;
			3'd3:    n = 3'd2;
			3'd4:    n = 3'd3;
			3'd5:    n = 3'd3;
			3'd6:    n = 3'd4;
			default: n = 3'd1;
		endcase
		return n;
	endfunction

	// Credits given per award
	function automatic logic [2:0] credits_award(input logic [2:0] mode);
		logic [2:0] n;
		case (mode)
			3'd0:    n = 3'd1;
			3'd1:    n = 3'd2;
			3'd2:    n = 3'd3;
			3'd3:    n = 3'd1;
			3'd4:    n = 3'd2;
			3'd5:    n = 3'd4;
			3'd6:    n = 3'd3;
			default: n = 3'd1;
		endcase
		return n;
	endfunction

endpackage

/* hw/rtl/ccc_core.sv */
`timescale 1ns / 1ps

module ccc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [2:0]       coin_mode,
	input  logic             step,
	input  ccc_pkg::ccc_in_t item,
	output ccc_pkg::ccc_out_t result
);

	logic       coin_prev_q;
	logic       service_prev_q;
	logic [6:0] credit_q;
	logic [2:0] tally_q;

	logic       coin_edge;
	logic       service_edge;
	logic       free;
	logic [2:0] tally_inc;
	logic       award_hit;
	logic [2:0] tally_d;
	logic [6:0] credit_a;
	logic [6:0] credit_b;
	logic [6:0] credit_d;
	logic       granted;

	// Saturating add, clamps at the credit ceiling
	function automatic logic [6:0] sat_add(input logic [6:0] base, input logic [2:0] amt);
		logic [7:0] sum;
		sum = {1'b0, base} + {5'b0, amt};
		return (sum > {1'b0, ccc_pkg::CreditMax}) ? ccc_pkg::CreditMax : sum[6:0];
	endfunction

	// Frame update: service, then coin, then start
	always_comb begin
		coin_edge    = item.coin_switch & ~coin_prev_q;
		service_edge = item.service_switch & ~service_prev_q;
		free         = (coin_mode == ccc_pkg::FreePlayMode);

		credit_a = service_edge ? sat_add(credit_q, 3'd1) : credit_q;

		tally_inc = tally_q + 3'd1;
		award_hit = (tally_inc >= ccc_pkg::coins_needed(coin_mode));
		tally_d   = tally_q;
		credit_b  = credit_a;
		if (coin_edge && !free) begin
			if (award_hit) begin
				tally_d  = 3'd0;
				credit_b = sat_add(credit_a, ccc_pkg::credits_award(coin_mode));
			end else begin
				tally_d = tally_inc;
			end
		end

		granted  = item.start_press & (free | (credit_b != 7'd0));
		credit_d = (granted && !free) ? credit_b - 7'd1 : credit_b;

		result.start_granted = granted;
		result.credits_now   = credit_d;
		result.free_play     = free;
	end

	// Per-frame state, advanced once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coin_prev_q    <= 1'b0;
			service_prev_q <= 1'b0;
			credit_q       <= 7'd0;
			tally_q        <= 3'd0;
		end else if (step) begin
			coin_prev_q    <= item.coin_switch;
			service_prev_q <= item.service_switch;
			credit_q       <= credit_d;
			tally_q        <= tally_d;
		end
	end

`ifndef SYNTHESIS
	a_credit_ceiling : assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= ccc_pkg::CreditMax)
		else $error("credit count above ceiling");

	a_tally_bound : assert property (@(posedge clk) disable iff (!arst_n)
		tally_q <= 3'd3)
		else $error("coin tally out of range");

	a_paid_grant_spends : assert property (@(posedge clk) disable iff (!arst_n)
		step && granted && !free |-> credit_d < ccc_pkg::CreditMax)
		else $error("paid start did not spend a credit");

	a_free_tally_kept : assert property (@(posedge clk) disable iff (!arst_n)
		step && free |=> tally_q == $past(tally_q))
		else $error("coin tally moved in free play");
`endif

endmodule

/* hw/rtl/coin_credit_counter_unit.sv */
`timescale 1ns / 1ps

// Coin and credit keeper for an arcade cabinet, one transaction per video frame.
// Takes one frame sample per clock cycle while the output is not stalled: the sample is
// registered, the credit update runs as one short step between that register and
// the result register, and the input register can take a new sample while the
// previous result waits on the output. Credits saturate at 99; coin_mode 7 is free play.
// The user must write coin_mode via the cfg channel only while no frame is in flight; the block does not enforce it.
module coin_credit_counter_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// Coin mode register
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [2:0]                   cfg_data,
	// Frame sample in
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// [0] coin_switch, [1] service_switch, [2] start_press, [7:3] zero
	input  logic [ccc_pkg::InDataW-1:0]  s_axis_tdata,
	// Frame result out
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [0] start_granted, [7:1] credits_now, [8] free_play, [15:9] zero
	output logic [ccc_pkg::OutDataW-1:0] m_axis_tdata
);

	logic              cfg_wr;
	logic [2:0]        coin_mode_q;
	logic              vld_s1;
	ccc_pkg::ccc_in_t  item_s1;
	logic              vld_s2;
	ccc_pkg::ccc_out_t res_s2;
	ccc_pkg::ccc_out_t res_comb;
	logic              adv_s1;

	// Configuration register
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coin_mode_q <= 3'd0;
		end else if (cfg_wr) begin
			coin_mode_q <= cfg_data;
		end
	end

	// Stage handshakes
	assign adv_s1        = vld_s1 & (~vld_s2 | m_axis_tready);
	assign s_axis_tready = ~vld_s1 | adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.coin_switch    <= s_axis_tdata[0];
			item_s1.service_switch <= s_axis_tdata[1];
			item_s1.start_press    <= s_axis_tdata[2];
		end
	end

	ccc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.coin_mode (coin_mode_q),
		.step      (adv_s1),
		.item      (item_s1),
		.result    (res_comb)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s1) begin
			vld_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {7'd0, res_s2.free_play, res_s2.credits_now, res_s2.start_granted};

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int          SettleCycles = 4;
	localparam int unsigned CycleLimit   = 400000;
	localparam int          HoldCycles   = 150;
	localparam int          MaxGap       = 18;

	// Coins needed and credits awarded per mode 0..6, three bits each, mode 0 lowest
	localparam logic [20:0] CoinsNeededTab  = {3'd4, 3'd3, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1};
	localparam logic [20:0] CreditsAwardTab = {3'd3, 3'd4, 3'd2, 3'd1, 3'd3, 3'd2, 3'd1};

	typedef enum logic [1:0] {
		StepFrame,
		StepMode,
		StepDrain
	} plan_kind_t;

	typedef struct {
		plan_kind_t        kind;
		ccc_pkg::ccc_in_t  frame;
		logic [2:0]        mode;
		int unsigned       gap;
	} plan_step_t;

	logic                         clk           = 1'b0;
	logic                         arst_n        = 1'b0;
	logic                         cfg_valid     = 1'b0;
	logic                         cfg_ready;
	logic [2:0]                   cfg_data      = '0;
	logic                         s_axis_tvalid = 1'b0;
	logic                         s_axis_tready;
	// [0] coin_switch, [1] service_switch, [2] start_press, [7:3] zero
	logic [ccc_pkg::InDataW-1:0]  s_axis_tdata  = '0;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready = 1'b0;
	// [0] start_granted, [7:1] credits_now, [8] free_play, [15:9] zero
	logic [ccc_pkg::OutDataW-1:0] m_axis_tdata;

	// Frames and mode writes waiting to go out, and results still owed by the block
	plan_step_t        feed_plan[$];
	ccc_pkg::ccc_out_t owed_results[$];

	// Shadow of the cabinet's coin and credit state
	logic [2:0] mode_m;
	logic       coin_prev_m;
	logic       service_prev_m;
	logic [6:0] credits_m;
	logic [2:0] tally_m;

	int          mismatches = 0;
	int          results_seen = 0;
	int unsigned cycle_count = 0;
	bit          sender_calm = 1'b0;

	// Driver bookkeeping
	int unsigned waited;
	int          settle;
	logic        frame_busy;
	logic        mode_busy;

	// Receiver bookkeeping
	int stall_left;
	int calm_left;
	int hold_left;
	int hold_seen;

	coin_credit_counter_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Saturating credit addition
	task automatic credit_add(input logic [2:0] amount);
		logic [7:0] sum;
		sum = {1'b0, credits_m} + {5'b0, amount};
		credits_m = (sum > {1'b0, ccc_pkg::CreditMax}) ? ccc_pkg::CreditMax : sum[6:0];
	endtask

	// One frame: service edge, then coin edge, then start; queues the owed result
	task automatic account_frame(input ccc_pkg::ccc_in_t f);
		ccc_pkg::ccc_out_t r;
		logic              coin_rise;
		logic              service_rise;
		logic              free_mode;
		coin_rise      = f.coin_switch && !coin_prev_m;
		service_rise   = f.service_switch && !service_prev_m;
		free_mode      = (mode_m == ccc_pkg::FreePlayMode);
		coin_prev_m    = f.coin_switch;
		service_prev_m = f.service_switch;
		if (service_rise)
			credit_add(3'd1);
		if (coin_rise && !free_mode) begin
			tally_m = tally_m + 3'd1;
			if (tally_m >= CoinsNeededTab[mode_m*3 +: 3]) begin
				tally_m = 3'd0;
				credit_add(CreditsAwardTab[mode_m*3 +: 3]);
			end
		end
		r.start_granted = 1'b0;
		if (f.start_press) begin
			if (free_mode) begin
				r.start_granted = 1'b1;
			end else if (credits_m != 7'd0) begin
				credits_m       = credits_m - 7'd1;
				r.start_granted = 1'b1;
			end
		end
		r.credits_now = credits_m;
		r.free_play   = free_mode;
		owed_results.push_back(r);
	endtask

	task automatic note_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s at result %0d: expected %0d, got %0d",
				what, results_seen, want, got);
	endtask

	task automatic push_frame(input logic coin, input logic service, input logic start);
		plan_step_t s;
		s.kind                 = StepFrame;
		s.frame.coin_switch    = coin;
		s.frame.service_switch = service;
		s.frame.start_press    = start;
		s.mode                 = 3'd0;
		s.gap                  = sender_calm ? 0 : $urandom_range(0, MaxGap);
		feed_plan.push_back(s);
	endtask

	task automatic push_step(input plan_kind_t kind, input logic [2:0] mode);
		plan_step_t s;
		s.kind  = kind;
		s.frame = '0;
		s.mode  = mode;
		s.gap   = 0;
		feed_plan.push_back(s);
	endtask

	// Driver: frames out on the slave stream, mode writes only once nothing is owed
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid  <= 1'b0;
			s_axis_tdata   <= '0;
			cfg_valid      <= 1'b0;
			cfg_data       <= '0;
			waited         = 0;
			settle         = 0;
			mode_m         = 3'd0;
			coin_prev_m    = 1'b0;
			service_prev_m = 1'b0;
			credits_m      = 7'd0;
			tally_m        = 3'd0;
		end else begin
			frame_busy = s_axis_tvalid;
			mode_busy  = cfg_valid;
			if (s_axis_tvalid && s_axis_tready) begin
				account_frame(ccc_pkg::ccc_in_t'(s_axis_tdata[2:0]));
				frame_busy = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				mode_m    = cfg_data;
				mode_busy = 1'b0;
			end
			// next planned step once both channels are free
			if (!frame_busy && !mode_busy && feed_plan.size() != 0) begin
				if (feed_plan[0].kind == StepFrame) begin
					settle = 0;
					if (waited < feed_plan[0].gap) begin
						waited++;
					end else begin
						s_axis_tdata <= {{(ccc_pkg::InDataW-3){1'b0}}, feed_plan[0].frame};
						frame_busy   = 1'b1;
						waited       = 0;
						void'(feed_plan.pop_front());
					end
				end else if (owed_results.size() != 0) begin
					settle = 0;
				end else if (settle < SettleCycles) begin
					settle++;
				end else begin
					settle = 0;
					if (feed_plan[0].kind == StepMode) begin
						cfg_data  <= feed_plan[0].mode;
						mode_busy = 1'b1;
					end
					void'(feed_plan.pop_front());
				end
			end
			s_axis_tvalid <= frame_busy;
			cfg_valid     <= mode_busy;
		end
	end

	// Long receiver hold-off, twice in the run, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_seen <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				hold_seen <= hold_seen + 1;
			if (hold_left != 0)
				hold_left <= hold_left - 1;
			else if (m_axis_tvalid && m_axis_tready && (hold_seen == 300 || hold_seen == 900))
				hold_left <= HoldCycles;
		end
	end

	// Monitor: compare each result transaction with the oldest owed one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left    = 0;
			calm_left     = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				ccc_pkg::ccc_out_t got;
				ccc_pkg::ccc_out_t want;
				got = ccc_pkg::ccc_out_t'(m_axis_tdata[8:0]);
				if (owed_results.size() == 0) begin
					note_mismatch("unowed result (credits shown)", -1, got.credits_now);
				end else begin
					want = owed_results.pop_front();
					if (got.start_granted !== want.start_granted)
						note_mismatch("start_granted", want.start_granted, got.start_granted);
					if (got.credits_now !== want.credits_now)
						note_mismatch("credits_now", want.credits_now, got.credits_now);
					if (got.free_play !== want.free_play)
						note_mismatch("free_play", want.free_play, got.free_play);
				end
				results_seen++;
				// stall before the next result, with calm stretches now and then
				if (calm_left != 0) begin
					calm_left--;
					stall_left = 0;
				end else begin
					if ($urandom_range(0, 15) == 0)
						calm_left = $urandom_range(20, 60);
					stall_left = $urandom_range(0, MaxGap);
				end
			end else if (stall_left != 0) begin
				stall_left--;
			end
			m_axis_tready <= (stall_left == 0) && (hold_left == 0);
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Stimulus plan and end of run
	initial begin
		int          planned;
		int          phase;
		int          len;
		int          start_pct;
		int          coin_flip;
		int          service_flip;
		logic [2:0]  mode;
		logic        coin_lvl;
		logic        service_lvl;

		// reset mode 0: start with no credits, coin, held coin, service and start together
		push_frame(1'b0, 1'b0, 1'b1);
		push_frame(1'b1, 1'b0, 1'b0);
		push_frame(1'b1, 1'b0, 1'b1);
		push_frame(1'b0, 1'b1, 1'b1);
		push_frame(1'b1, 1'b1, 1'b0);
		push_frame(1'b0, 1'b0, 1'b0);
		push_frame(1'b1, 1'b1, 1'b1);
		// build a tally in mode 6, then finish it under mode 3
		push_step(StepMode, 3'd6);
		push_frame(1'b0, 1'b0, 1'b0);
		push_frame(1'b1, 1'b0, 1'b0);
		push_frame(1'b0, 1'b0, 1'b0);
		push_frame(1'b1, 1'b0, 1'b0);
		push_step(StepMode, 3'd3);
		push_frame(1'b0, 1'b0, 1'b0);
		push_frame(1'b1, 1'b0, 1'b0);
		// free play: coin ignored, service still credits, start always granted
		push_step(StepMode, ccc_pkg::FreePlayMode);
		push_frame(1'b0, 1'b0, 1'b1);
		push_frame(1'b1, 1'b0, 1'b0);
		push_frame(1'b1, 1'b1, 1'b0);
		push_frame(1'b1, 1'b0, 1'b1);
		// leave free play with coin held: no edge, then a fresh edge
		push_step(StepMode, 3'd5);
		push_frame(1'b1, 1'b0, 1'b1);
		push_frame(1'b0, 1'b0, 1'b1);
		push_frame(1'b1, 1'b0, 1'b0);
		push_frame(1'b0, 1'b1, 1'b1);

		// random phases, each under one coin mode
		planned     = 0;
		phase       = 0;
		coin_lvl    = 1'b0;
		service_lvl = 1'b0;
		while (planned < 1300) begin
			if ($urandom_range(0, 3) == 0)
				push_step(StepDrain, 3'd0);
			sender_calm  = ($urandom_range(0, 3) == 0);
			mode         = (phase < 8) ? phase[2:0] : 3'($urandom_range(0, 7));
			len          = $urandom_range(40, 110);
			start_pct    = ($urandom_range(0, 2) == 0) ? 3 : $urandom_range(10, 80);
			coin_flip    = $urandom_range(20, 90);
			service_flip = $urandom_range(0, 40);
			// first phases drive credits to the ceiling and then back to zero
			if (phase == 0) begin
				mode      = 3'd2;
				len       = 100;
				start_pct = 2;
				coin_flip = 100;
			end else if (phase == 1) begin
				mode         = 3'd0;
				len          = 120;
				start_pct    = 90;
				coin_flip    = 5;
				service_flip = 5;
			end
			push_step(StepMode, mode);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 99) < coin_flip)
					coin_lvl = ~coin_lvl;
				if ($urandom_range(0, 99) < service_flip)
					service_lvl = ~service_lvl;
				push_frame(coin_lvl, service_lvl, $urandom_range(0, 99) < start_pct);
			end
			planned += len;
			phase++;
		end
		push_step(StepMode, 3'd0);

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (feed_plan.size() != 0 || s_axis_tvalid || cfg_valid || owed_results.size() != 0)
			@(posedge clk);
		repeat (2 * SettleCycles) @(posedge clk);

		if (mismatches == 0 && owed_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
